// ----- rtl/scf_pkg.sv -----
// shared constants, payload types and helpers of the spring constraint force block
package scf_pkg;

  localparam int unsigned CW = 24;
  localparam int unsigned F = 8;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned SW = 2 * DW;
  localparam int unsigned RW = SW + 1;
  localparam int unsigned SQ_STEPS = DW;
  localparam int unsigned SQ_IW = $clog2(SQ_STEPS);
  localparam int unsigned NW = DW + F;
  localparam int unsigned QW = F + 1;
  localparam int unsigned DV_IW = $clog2(QW);
  localparam int unsigned EW = DW + 1;
  localparam int unsigned PW = QW + DW;

  localparam logic [PW-1:0] SAT_LIM = PW'(1) << (CW - 1);
  localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic [CW-2:0]        rest_length;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] force_x;
    logic signed [CW-1:0] force_y;
    logic signed [CW-1:0] shift_x;
    logic signed [CW-1:0] shift_y;
    logic                 apply;
  } out_t;

  typedef struct packed {
    logic [DW-1:0] adx;
    logic [DW-1:0] ady;
    logic [CW-2:0] rest;
    logic          nxneg;
    logic          nyneg;
    logic          zero;
  } side_t;

  function automatic logic [CW-1:0] sat_out(input logic [PW-1:0] m, input logic neg);
    logic [PW-1:0] nm;
    nm = ~m + PW'(1);
    if (neg) begin
      sat_out = (m > SAT_LIM) ? SAT_MIN : nm[CW-1:0];
    end else begin
      sat_out = (m >= SAT_LIM) ? SAT_MAX : m[CW-1:0];
    end
  endfunction

endpackage

// ----- rtl/scf_sqrt_cell.sv -----
// one digit step of the integer square root chain
module scf_sqrt_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [scf_pkg::SQ_IW-1:0] idx_i,
  input  logic                      valid_i,
  input  logic [scf_pkg::SW-1:0]    x_i,
  input  logic [scf_pkg::RW-1:0]    r_i,
  input  scf_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [scf_pkg::SW-1:0]    x_o,
  output logic [scf_pkg::RW-1:0]    r_o,
  output scf_pkg::side_t            side_o
);
  import scf_pkg::*;

  logic [RW-1:0] b;
  logic [RW-1:0] trial;
  logic          take;
  logic [SW-1:0] x_d, x_q;
  logic [RW-1:0] r_d, r_q;
  logic          valid_q;
  side_t         side_q;

  assign b     = RW'(1) << {idx_i, 1'b0};
  assign trial = r_i + b;
  assign take  = {1'b0, x_i} >= trial;
  assign x_d   = take ? (x_i - trial[SW-1:0]) : x_i;
  assign r_d   = take ? ((r_i >> 1) + b) : (r_i >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      r_q    <= r_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign r_o     = r_q;
  assign side_o  = side_q;
endmodule

// ----- rtl/scf_div_cell.sv -----
// one quotient bit of both direction divisions
module scf_div_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [scf_pkg::DV_IW-1:0] idx_i,
  input  logic                      valid_i,
  input  logic [scf_pkg::NW-1:0]    rem_x_i,
  input  logic [scf_pkg::NW-1:0]    rem_y_i,
  input  logic [scf_pkg::QW-1:0]    qx_i,
  input  logic [scf_pkg::QW-1:0]    qy_i,
  input  logic [scf_pkg::DW-1:0]    dist_i,
  input  scf_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [scf_pkg::NW-1:0]    rem_x_o,
  output logic [scf_pkg::NW-1:0]    rem_y_o,
  output logic [scf_pkg::QW-1:0]    qx_o,
  output logic [scf_pkg::QW-1:0]    qy_o,
  output logic [scf_pkg::DW-1:0]    dist_o,
  output scf_pkg::side_t            side_o
);
  import scf_pkg::*;

  logic [NW-1:0] dsh;
  logic [QW-1:0] qbit;
  logic          tx, ty;
  logic          valid_q;
  logic [NW-1:0] rem_x_q, rem_y_q;
  logic [QW-1:0] qx_q, qy_q;
  logic [DW-1:0] dist_q;
  side_t         side_q;

  assign dsh  = NW'(dist_i) << idx_i;
  assign qbit = QW'(1) << idx_i;
  assign tx   = rem_x_i >= dsh;
  assign ty   = rem_y_i >= dsh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_x_q <= tx ? (rem_x_i - dsh) : rem_x_i;
      rem_y_q <= ty ? (rem_y_i - dsh) : rem_y_i;
      qx_q    <= tx ? (qx_i | qbit) : qx_i;
      qy_q    <= ty ? (qy_i | qbit) : qy_i;
      dist_q  <= dist_i;
      side_q  <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_x_o = rem_x_q;
  assign rem_y_o = rem_y_q;
  assign qx_o    = qx_q;
  assign qy_o    = qy_q;
  assign dist_o  = dist_q;
  assign side_o  = side_q;
endmodule

// ----- rtl/spring_constraint_force.sv -----
// top level of the spring constraint force pipeline
//
// in channel: in_valid_i / in_ready_o with one spring per beat (in_i: both end
// points and the rest length). out channel: out_valid_o / out_ready_i with one
// result per beat (out_o: force and position correction for point A, point B
// takes the negation; apply is low when the points coincide).
// throughput: one spring per cycle while the receiver takes results.
// from the accepting edge to out_valid_o an item passes the registers after the
// input stage: a squaring stage, 25 square root cells (one root bit
// each), 9 division cells (one quotient bit for both axes each), a multiply
// stage and the output register.
// the whole chain advances together; when the receiver stalls with a result
// waiting, every stage holds and in_ready_o drops until the result is taken.
// reset clears the valid bit of every stage; no item is in flight afterwards.
module spring_constraint_force (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  scf_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output scf_pkg::out_t  out_o
);
  import scf_pkg::*;

  logic en;
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // input stage
  logic [DW-1:0] dx, dy;
  side_t         s0_d, s0_q;
  logic          s0_v_q;

  assign dx = {in_i.bx[CW-1], in_i.bx} - {in_i.ax[CW-1], in_i.ax};
  assign dy = {in_i.by[CW-1], in_i.by} - {in_i.ay[CW-1], in_i.ay};

  always_comb begin
    s0_d.nxneg = dx[DW-1];
    s0_d.nyneg = dy[DW-1];
    s0_d.adx   = dx[DW-1] ? (~dx + DW'(1)) : dx;
    s0_d.ady   = dy[DW-1] ? (~dy + DW'(1)) : dy;
    s0_d.rest  = in_i.rest_length;
    s0_d.zero  = (dx == '0) && (dy == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= s0_d;
    end
  end

  // squaring stage
  logic [SW-1:0] s1_x_q;
  side_t         s1_q;
  logic          s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x_q <= (SW'(s0_q.adx) * SW'(s0_q.adx)) + (SW'(s0_q.ady) * SW'(s0_q.ady));
      s1_q   <= s0_q;
    end
  end

  // square root chain
  logic          sq_v [SQ_STEPS+1];
  logic [SW-1:0] sq_x [SQ_STEPS+1];
  logic [RW-1:0] sq_r [SQ_STEPS+1];
  side_t         sq_s [SQ_STEPS+1];

  assign sq_v[0] = s1_v_q;
  assign sq_x[0] = s1_x_q;
  assign sq_r[0] = '0;
  assign sq_s[0] = s1_q;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    scf_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (SQ_IW'(SQ_STEPS - 1 - k)),
      .valid_i (sq_v[k]),
      .x_i     (sq_x[k]),
      .r_i     (sq_r[k]),
      .side_i  (sq_s[k]),
      .valid_o (sq_v[k+1]),
      .x_o     (sq_x[k+1]),
      .r_o     (sq_r[k+1]),
      .side_o  (sq_s[k+1])
    );
  end

  // division chain
  logic          dv_v  [QW+1];
  logic [NW-1:0] dv_rx [QW+1];
  logic [NW-1:0] dv_ry [QW+1];
  logic [QW-1:0] dv_qx [QW+1];
  logic [QW-1:0] dv_qy [QW+1];
  logic [DW-1:0] dv_d  [QW+1];
  side_t         dv_s  [QW+1];

  assign dv_v[0]  = sq_v[SQ_STEPS];
  assign dv_rx[0] = {sq_s[SQ_STEPS].adx, F'(0)};
  assign dv_ry[0] = {sq_s[SQ_STEPS].ady, F'(0)};
  assign dv_qx[0] = '0;
  assign dv_qy[0] = '0;
  assign dv_d[0]  = sq_r[SQ_STEPS][DW-1:0];
  assign dv_s[0]  = sq_s[SQ_STEPS];

  for (genvar k = 0; k < QW; k++) begin : g_div
    scf_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (DV_IW'(QW - 1 - k)),
      .valid_i (dv_v[k]),
      .rem_x_i (dv_rx[k]),
      .rem_y_i (dv_ry[k]),
      .qx_i    (dv_qx[k]),
      .qy_i    (dv_qy[k]),
      .dist_i  (dv_d[k]),
      .side_i  (dv_s[k]),
      .valid_o (dv_v[k+1]),
      .rem_x_o (dv_rx[k+1]),
      .rem_y_o (dv_ry[k+1]),
      .qx_o    (dv_qx[k+1]),
      .qy_o    (dv_qy[k+1]),
      .dist_o  (dv_d[k+1]),
      .side_o  (dv_s[k+1])
    );
  end

  // length error and multiply stage
  logic [EW-1:0] err;
  logic          eneg;
  logic [EW-1:0] aerr;
  logic [PW-1:0] px_q, py_q;
  logic          negx_q, negy_q, zero_q, m_v_q;

  assign err  = {1'b0, dv_d[QW]} - {3'b000, dv_s[QW].rest};
  assign eneg = err[EW-1];
  assign aerr = eneg ? (~err + EW'(1)) : err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= dv_v[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q   <= PW'(dv_qx[QW]) * PW'(aerr[DW-1:0]);
      py_q   <= PW'(dv_qy[QW]) * PW'(aerr[DW-1:0]);
      negx_q <= dv_s[QW].nxneg ^ eneg;
      negy_q <= dv_s[QW].nyneg ^ eneg;
      zero_q <= dv_s[QW].zero;
    end
  end

  // saturation and output register
  out_t out_d, out_q;
  logic out_valid_q;

  always_comb begin
    if (zero_q) begin
      out_d = '0;
    end else begin
      out_d.force_x = sat_out(px_q >> (F - 2), negx_q);
      out_d.force_y = sat_out(py_q >> (F - 2), negy_q);
      out_d.shift_x = sat_out(px_q >> (F + 1), negx_q);
      out_d.shift_y = sat_out(py_q >> (F + 1), negy_q);
      out_d.apply   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready_o does not follow the output stall");

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.apply |-> out_o.force_x == '0 && out_o.force_y == '0
      && out_o.shift_x == '0 && out_o.shift_y == '0)
    else $error("coincident points gave a nonzero result");

  a_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s1_q.zero |-> s1_x_q == '0)
    else $error("coincident points gave a nonzero square sum");

  a_root_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_d[0]) && $stable(sq_v[SQ_STEPS]))
    else $error("square root chain moved during a stall");
`endif
endmodule
